// File: hdl/fqkl_pkg.sv
// shared types and codes for the keyed fifo queue
package fqkl_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_LOOKUP,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REMOVE,
    BK_LOOKUP
  } back_state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key;
    logic [31:0]        info_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] info_out;
    logic [4:0]  count;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic [31:0] info;
  } job_t;

endpackage

// File: hdl/fqkl_front.sv
// front end: accepts beats, decodes the command and holds them in a two entry queue
module fqkl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fqkl_pkg::in_t in_data_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output fqkl_pkg::job_t job_o
);

  fqkl_pkg::job_t q_mem [2];
  fqkl_pkg::job_t new_job;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  always_comb begin
    new_job.key  = in_data_i.key;
    new_job.info = in_data_i.info_in;
    case (in_data_i.cmd)
      fqkl_pkg::CMD_INSERT: new_job.op = fqkl_pkg::OP_INSERT;
      fqkl_pkg::CMD_REMOVE: new_job.op = fqkl_pkg::OP_REMOVE;
      fqkl_pkg::CMD_LOOKUP: new_job.op = fqkl_pkg::OP_LOOKUP;
      default:              new_job.op = fqkl_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign job_valid_o = (fill_q != 2'd0);
  assign job_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_job;
    end
  end

endmodule

// File: hdl/fqkl_back.sv
// back end: ring storage, pointers, key scan and result register
module fqkl_back #(
  parameter int DEPTH      = 16,
  parameter int INFO_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  fqkl_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fqkl_pkg::out_t out_data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (INFO_WIDTH < 32) ? INFO_WIDTH : 32;

  fqkl_pkg::back_state_e state_q, state_d;

  logic [31:0]   key_mem  [DEPTH];
  logic [IW-1:0] info_mem [DEPTH];
  logic [31:0]   rd_key_q;
  logic [IW-1:0] rd_info_q;
  logic          wr_en;
  logic [PW-1:0] rd_addr;

  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [PW-1:0] scan_q, scan_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] left_q, left_d;
  logic [31:0]   jkey_q, jkey_d;

  logic           out_valid_q, out_valid_d;
  fqkl_pkg::out_t out_q, out_d;

  logic          slot_free, pop, hit, last, is_empty, is_full;
  logic          res_load;
  fqkl_pkg::status_e res_status;
  logic [IW-1:0] res_info;
  logic [CW-1:0] res_cnt;
  logic [31:0]   res_cnt_wide;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign slot_free   = !out_valid_q || out_ready_i;
  assign job_ready_o = (state_q == fqkl_pkg::BK_IDLE) && slot_free;
  assign pop         = job_valid_i && job_ready_o;
  assign hit         = (rd_key_q == jkey_q);
  assign last        = (left_q == CW'(1));
  assign is_empty    = (cnt_q == '0);
  assign is_full     = (cnt_q == CW'(DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fqkl_pkg::BK_IDLE: begin
        if (pop && !is_empty) begin
          if (job_i.op == fqkl_pkg::OP_REMOVE) begin
            state_d = fqkl_pkg::BK_REMOVE;
          end else if (job_i.op == fqkl_pkg::OP_LOOKUP) begin
            state_d = fqkl_pkg::BK_LOOKUP;
          end
        end
      end
      fqkl_pkg::BK_REMOVE: state_d = fqkl_pkg::BK_IDLE;
      fqkl_pkg::BK_LOOKUP: begin
        if (hit || last) begin
          state_d = fqkl_pkg::BK_IDLE;
        end
      end
      default: state_d = fqkl_pkg::BK_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    scan_d     = scan_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    jkey_d     = jkey_q;
    wr_en      = 1'b0;
    rd_addr    = head_q;
    res_load   = 1'b0;
    res_status = fqkl_pkg::ST_OK;
    res_info   = '0;
    res_cnt    = cnt_q;
    case (state_q)
      fqkl_pkg::BK_IDLE: begin
        if (pop) begin
          // head entry is read on this edge for remove and for the first compare
          jkey_d = job_i.key;
          scan_d = ptr_next(head_q);
          left_d = cnt_q;
          case (job_i.op)
            fqkl_pkg::OP_INSERT: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status = fqkl_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                tail_d  = ptr_next(tail_q);
                cnt_d   = CW'(cnt_q + 1'b1);
                res_cnt = CW'(cnt_q + 1'b1);
              end
            end
            fqkl_pkg::OP_REMOVE, fqkl_pkg::OP_LOOKUP: begin
              if (is_empty) begin
                res_load   = 1'b1;
                res_status = fqkl_pkg::ST_EMPTY;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      fqkl_pkg::BK_REMOVE: begin
        head_d   = ptr_next(head_q);
        cnt_d    = CW'(cnt_q - 1'b1);
        res_load = 1'b1;
        res_info = rd_info_q;
        res_cnt  = CW'(cnt_q - 1'b1);
      end
      fqkl_pkg::BK_LOOKUP: begin
        // one read issued and one key compared per cycle
        rd_addr = scan_q;
        scan_d  = ptr_next(scan_q);
        left_d  = CW'(left_q - 1'b1);
        if (hit) begin
          res_load = 1'b1;
          res_info = rd_info_q;
        end else if (last) begin
          res_load   = 1'b1;
          res_status = fqkl_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_cnt_wide = 32'(res_cnt);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (res_load) begin
      out_valid_d    = 1'b1;
      out_d.status   = res_status;
      out_d.info_out = 32'(res_info);
      out_d.count    = res_cnt_wide[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fqkl_pkg::BK_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    left_q <= left_d;
    jkey_q <= jkey_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[tail_q]  <= job_i.key;
      info_mem[tail_q] <= job_i.info[IW-1:0];
    end
    rd_key_q  <= key_mem[rd_addr];
    rd_info_q <= info_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/fifo_queue_with_key_lookup_top.sv
// top level of the fifo queue with key lookup
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o  | in_data_i  (cmd, key, info_in)
//  out     | output    | out_valid_o/out_ready_i| out_data_o (status, info_out, count)
//
// insert and unused commands are answered from the idle state, remove passes the remove
// state, lookup compares n records (at most the count, so at most DEPTH) in its scan;
// the single read port of the key store compares one key per cycle.
// a two entry queue sits in front and a result register at the back, so beats are
// taken while a result waits. reset clears pointers, counts, state and output valid
// only; the stores need no clearing pass since only held records are ever read.
module fifo_queue_with_key_lookup_top #(
  parameter int DEPTH      = 16,
  parameter int INFO_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fqkl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fqkl_pkg::out_t out_data_o
);

  logic           job_valid;
  logic           job_ready;
  fqkl_pkg::job_t job;

  fqkl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  fqkl_back #(
    .DEPTH      (DEPTH),
    .INFO_WIDTH (INFO_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hdl/fqkl_check.sv
// port level checks for the keyed fifo queue, bound to the top level
module fqkl_check #(
  parameter int DEPTH = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input fqkl_pkg::out_t out_data_o
);

  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // full is only reported with the ring at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == fqkl_pkg::ST_FULL)
      |-> out_data_o.count == DEPTH_W[4:0])
    else $error("full status with wrong count");

  // empty is only reported with no records held
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == fqkl_pkg::ST_EMPTY)
      |-> out_data_o.count == 5'd0)
    else $error("empty status with nonzero count");

  // failed operations carry no info
  a_fail_info: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != fqkl_pkg::ST_OK) |-> out_data_o.info_out == 32'd0)
    else $error("info on a failed operation");

endmodule

bind fifo_queue_with_key_lookup_top fqkl_check #(
  .DEPTH (DEPTH)
) u_fqkl_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: tb/tb_top.sv
// self-checking testbench for the keyed fifo queue: directed table, then random traffic
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH      = 16;
  localparam int INFO_WIDTH = 32;
  localparam logic [31:0] INFO_MASK = {32{1'b1}} >> (32 - INFO_WIDTH);
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RAND_ITEMS    = 1650;
  localparam int SEG_ITEMS     = 150;
  localparam int QUIET_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 2 * DEPTH + 8;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    fqkl_pkg::in_t  beat;
    bit             typed;
    fqkl_pkg::out_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  fqkl_pkg::in_t  in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  fqkl_pkg::out_t out_data_o;

  // side info that travels with the beat on the input channel
  bit   cur_typed = 1'b0;
  fqkl_pkg::out_t cur_want = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int fail_count = 0;

  fqkl_pkg::out_t pending_results[$];

  // queue state mirrored by the predictor
  logic [31:0] held_keys [DEPTH];
  logic [31:0] held_info [DEPTH];
  int unsigned held_head = 0;
  int unsigned held_tail = 0;
  int unsigned held_count = 0;

  logic [31:0] key_pool [8];

  fifo_queue_with_key_lookup_top #(
    .DEPTH      (DEPTH),
    .INFO_WIDTH (INFO_WIDTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic fqkl_pkg::out_t apply_queue_op(fqkl_pkg::in_t b);
    fqkl_pkg::out_t res;
    int unsigned p;
    bit found;
    res = '0;
    found = 1'b0;
    case (b.cmd)
      fqkl_pkg::CMD_INSERT: begin
        if (held_count >= DEPTH) begin
          res.status = fqkl_pkg::ST_FULL;
        end else begin
          held_keys[held_tail] = b.key;
          held_info[held_tail] = b.info_in & INFO_MASK;
          held_tail = (held_tail + 1) % DEPTH;
          held_count++;
        end
      end
      fqkl_pkg::CMD_REMOVE: begin
        if (held_count == 0) begin
          res.status = fqkl_pkg::ST_EMPTY;
        end else begin
          res.info_out = held_info[held_head];
          held_head = (held_head + 1) % DEPTH;
          held_count--;
        end
      end
      fqkl_pkg::CMD_LOOKUP: begin
        if (held_count == 0) begin
          res.status = fqkl_pkg::ST_EMPTY;
        end else begin
          p = held_head;
          // oldest match wins
          for (int i = 0; i < held_count; i++) begin
            if (!found && held_keys[p] == b.key) begin
              found = 1'b1;
              res.info_out = held_info[p];
            end
            p = (p + 1) % DEPTH;
          end
          if (!found) res.status = fqkl_pkg::ST_NOT_FOUND;
        end
      end
      default: res.status = fqkl_pkg::ST_OK;
    endcase
    res.count = held_count[4:0];
    return res;
  endfunction

  function automatic stim_row_t make_row(logic [1:0] cmd, logic [31:0] key, logic [31:0] info,
                                         bit typed, fqkl_pkg::status_e st,
                                         logic [31:0] info_out, logic [4:0] cnt);
    stim_row_t row;
    row.beat.cmd      = cmd;
    row.beat.key      = key;
    row.beat.info_in  = info;
    row.typed         = typed;
    row.want.status   = st;
    row.want.info_out = info_out;
    row.want.count    = cnt;
    return row;
  endfunction

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("error: %s", msg);
  endtask

  // monitor: predicts on accepted input beats, checks accepted output beats
  always @(posedge clk_i) begin : monitor
    fqkl_pkg::out_t predicted;
    fqkl_pkg::out_t want;
    bit in_beat;
    bit out_beat;
    in_beat = (in_valid === 1'b1) && (in_ready_o === 1'b1);
    out_beat = (out_valid_o === 1'b1) && (out_ready === 1'b1);
    if (in_beat) begin
      predicted = apply_queue_op(in_data);
      pending_results.push_back(cur_typed ? cur_want : predicted);
    end
    if (out_beat) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result with none expected: status %0d info %h count %0d",
                                 out_data_o.status, out_data_o.info_out, out_data_o.count));
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_failure($sformatf("status expected %0d got %0d",
                                   want.status, out_data_o.status));
        if (out_data_o.info_out !== want.info_out)
          report_failure($sformatf("info_out expected %h got %h",
                                   want.info_out, out_data_o.info_out));
        if (out_data_o.count !== want.count)
          report_failure($sformatf("count expected %0d got %0d",
                                   want.count, out_data_o.count));
      end
    end
    quiet_cycles <= (in_beat || out_beat) ? 0 : quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // valid stays high across back-to-back beats; it only drops during a gap
  task automatic send_beat(fqkl_pkg::in_t b, bit typed, fqkl_pkg::out_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_data   <= b;
    cur_typed <= typed;
    cur_want  <= want;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    stim_row_t dir_rows[$];
    fqkl_pkg::in_t beat;
    logic [31:0] ins_key;
    logic [31:0] ins_info;
    int insert_pct;
    int r;
    int unsigned idx;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0000_0000;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    // empty queue cases
    dir_rows.push_back(make_row(fqkl_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b1,
                                fqkl_pkg::ST_EMPTY, 32'h0, 5'd0));
    dir_rows.push_back(make_row(fqkl_pkg::CMD_LOOKUP, 32'h0, 32'h0, 1'b1,
                                fqkl_pkg::ST_EMPTY, 32'h0, 5'd0));
    dir_rows.push_back(make_row(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
                                fqkl_pkg::ST_OK, 32'h0, 5'd0));
    // fill to the top, with a duplicate key early on
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: ins_key = 32'h8000_0000;
        1: ins_key = 32'h7fff_ffff;
        2, 4: ins_key = 32'hffff_ffff;
        3: ins_key = 32'h0000_0000;
        default: ins_key = i * 32'h0101_0101 + 32'h1000;
      endcase
      ins_info = (i == 0) ? 32'hffff_ffff : (i == 1) ? 32'h0 : (32'ha5a5_0000 | i);
      dir_rows.push_back(make_row(fqkl_pkg::CMD_INSERT, ins_key, ins_info, 1'b1,
                                  fqkl_pkg::ST_OK, 32'h0, 5'(i + 1)));
    end
    dir_rows.push_back(make_row(fqkl_pkg::CMD_INSERT, 32'h1234_5678, 32'hdead_beef, 1'b1,
                                fqkl_pkg::ST_FULL, 32'h0, 5'(DEPTH)));
    dir_rows.push_back(make_row(fqkl_pkg::CMD_LOOKUP, 32'hffff_ffff, 32'h0, 1'b0,
                                fqkl_pkg::ST_OK, 32'h0, 5'd0));
    dir_rows.push_back(make_row(fqkl_pkg::CMD_LOOKUP, (DEPTH - 1) * 32'h0101_0101 + 32'h1000,
                                32'h0, 1'b0, fqkl_pkg::ST_OK, 32'h0, 5'd0));
    dir_rows.push_back(make_row(fqkl_pkg::CMD_LOOKUP, 32'h0000_0001, 32'h0, 1'b1,
                                fqkl_pkg::ST_NOT_FOUND, 32'h0, 5'(DEPTH)));
    dir_rows.push_back(make_row(fqkl_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b0,
                                fqkl_pkg::ST_OK, 32'h0, 5'd0));
    dir_rows.push_back(make_row(CMD_UNUSED, 32'h0, 32'h0, 1'b0,
                                fqkl_pkg::ST_OK, 32'h0, 5'd0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    insert_pct = 50;
    for (int seg = 0; seg < RAND_ITEMS / SEG_ITEMS; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // swing between filling and draining so full and empty both come up
        if (n % 40 == 0) begin
          r = $urandom_range(2);
          insert_pct = (r == 0) ? 80 : (r == 1) ? 20 : 50;
        end
        beat.info_in = $urandom;
        r = $urandom_range(99);
        if (r < 5) begin
          beat.cmd = CMD_UNUSED;
        end else if (r < 5 + insert_pct * 95 / 100) begin
          beat.cmd = fqkl_pkg::CMD_INSERT;
        end else begin
          beat.cmd = ($urandom_range(99) < 40) ? fqkl_pkg::CMD_REMOVE : fqkl_pkg::CMD_LOOKUP;
        end
        r = $urandom_range(99);
        if (beat.cmd == fqkl_pkg::CMD_LOOKUP && r < 50 && held_count > 0) begin
          idx = (held_head + $urandom_range(held_count - 1)) % DEPTH;
          beat.key = held_keys[idx];
        end else if (r < 80) begin
          beat.key = key_pool[$urandom_range(7)];
        end else begin
          beat.key = $urandom;
        end
        send_beat(beat, 1'b0, '0);
      end
      if (seg % 2 == 1) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_failure($sformatf("%0d results never came", pending_results.size()));
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
